### hdl/kts_pkg.sv
`default_nettype none
package kts_pkg;

    localparam int MAX_KEYS   = 64;
    localparam int COMPONENTS = 3;
    localparam int VAL_DEPTH  = MAX_KEYS * COMPONENTS;
    localparam int KEY_W      = $clog2(MAX_KEYS);
    localparam int VAL_AW     = $clog2(VAL_DEPTH);
    localparam int COMP_W     = 2;
    localparam int CNT_W      = 7;
    localparam int MODE_W     = 2;
    localparam int STEP_W     = 6;
    localparam int Q_W        = 32;
    localparam int ALPHA_W    = 17;
    localparam int H_W        = 20;
    localparam int PROD_W     = 66;

    localparam int IN_TDATA_W  = 176;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_DATA_W  = 7;

    localparam logic [STEP_W-1:0] MOD_STEPS = STEP_W'(Q_W + 1);
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(16);

    localparam logic [MODE_W-1:0] MODE_STEP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic REG_INTERP_MODE = 1'b0;
    localparam logic REG_KEY_COUNT   = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE, S_CHK, S_RD1, S_RD2, S_RANGE, S_MOD, S_MODFIX, S_LOC,
        S_SRD, S_SCMP, S_T0, S_T1, S_T2, S_DCHK, S_DIV, S_POLY,
        S_TT, S_TTM, S_TTT, S_H, S_CRDA, S_CRDB, S_DIRECT, S_P2,
        S_LMUL, S_LRES, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8,
        S_EMIT
    } t_state;

    typedef enum logic [5:0] {
        DP_NOP, DP_CAPTURE, DP_BAD, DP_RD_START, DP_RD_END, DP_LATCH_END,
        DP_MOD_INIT, DP_MOD_STEP, DP_MOD_FIX, DP_CLAMP, DP_LOCATE,
        DP_SRCH_RD, DP_SRCH_CMP, DP_T0_RD, DP_T1_RD, DP_DELTA,
        DP_ALPHA_SET, DP_DIV_STEP, DP_MUL_AA, DP_LATCH_TT, DP_MUL_TA,
        DP_LATCH_TTT, DP_H_CALC, DP_CRD_A, DP_CRD_B, DP_DIRECT,
        DP_LATCH_P2, DP_LIN_MUL, DP_LIN_RES, DP_C1, DP_C2, DP_C3, DP_C4,
        DP_C5, DP_C6, DP_C7, DP_C8, DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        logic size_lt2;
        logic range_bad;
        logic wrap;
        logic cnt_done;
        logic t_le_start;
        logic t_ge_end;
        logic last_one;
        logic hit;
        logic i_one;
        logic direct;
        logic delta_le0;
        logic alpha_fixed;
        logic cubic;
        logic linear;
        logic bad;
        logic comp_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic signed [PROD_W-1:0] f_round16(
        input logic signed [PROD_W-1:0] x);
        return (x + PROD_W'(32768)) >>> 16;
    endfunction

    function automatic logic signed [Q_W-1:0] f_sat32(
        input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sh7FFFFFFF);
        lo = -PROD_W'(64'sh80000000);
        if (x > hi) begin
            return 32'sh7FFFFFFF;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[Q_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hdl/kts_ctrl.sv
`default_nettype none
module kts_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire kts_pkg::t_dp_stat i_stat,
    output kts_pkg::t_dp_cmd       o_cmd
);
    import kts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.func == FUNC_SAMPLE) n_state = S_CHK;
            end
            S_CHK:    n_state = i_stat.size_lt2 ? S_EMIT : S_RD1;
            S_RD1:    n_state = S_RD2;
            S_RD2:    n_state = S_RANGE;
            S_RANGE: begin
                priority if (i_stat.range_bad) n_state = S_EMIT;
                else if (i_stat.wrap)          n_state = S_MOD;
                else                           n_state = S_LOC;
            end
            S_MOD:    n_state = i_stat.cnt_done ? S_MODFIX : S_MOD;
            S_MODFIX: n_state = S_LOC;
            S_LOC: begin
                if (i_stat.t_le_start || i_stat.t_ge_end || i_stat.last_one) begin
                    n_state = S_T0;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD:    n_state = S_SCMP;
            S_SCMP:   n_state = (i_stat.hit || i_stat.i_one) ? S_T0 : S_SRD;
            S_T0:     n_state = i_stat.direct ? S_CRDA : S_T1;
            S_T1:     n_state = S_T2;
            S_T2:     n_state = S_DCHK;
            S_DCHK: begin
                priority if (i_stat.delta_le0) n_state = S_EMIT;
                else if (i_stat.alpha_fixed)   n_state = S_POLY;
                else                           n_state = S_DIV;
            end
            S_DIV:    n_state = i_stat.cnt_done ? S_POLY : S_DIV;
            S_POLY:   n_state = i_stat.cubic ? S_TT : S_CRDA;
            S_TT:     n_state = S_TTM;
            S_TTM:    n_state = S_TTT;
            S_TTT:    n_state = S_H;
            S_H:      n_state = S_CRDA;
            S_CRDA:   n_state = S_CRDB;
            S_CRDB:   n_state = i_stat.direct ? S_DIRECT : S_P2;
            S_DIRECT: n_state = S_EMIT;
            S_P2:     n_state = i_stat.linear ? S_LMUL : S_C1;
            S_LMUL:   n_state = S_LRES;
            S_LRES:   n_state = S_EMIT;
            S_C1:     n_state = S_C2;
            S_C2:     n_state = S_C3;
            S_C3:     n_state = S_C4;
            S_C4:     n_state = S_C5;
            S_C5:     n_state = S_C6;
            S_C6:     n_state = S_C7;
            S_C7:     n_state = S_C8;
            S_C8:     n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.out_free) begin
                    priority if (i_stat.comp_last) n_state = S_IDLE;
                    else if (i_stat.bad)           n_state = S_EMIT;
                    else                           n_state = S_CRDA;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = DP_CAPTURE;
            end
            S_CHK:    o_cmd.op = i_stat.size_lt2 ? DP_BAD : DP_RD_START;
            S_RD1:    o_cmd.op = DP_RD_END;
            S_RD2:    o_cmd.op = DP_LATCH_END;
            S_RANGE: begin
                priority if (i_stat.range_bad) o_cmd.op = DP_BAD;
                else if (i_stat.wrap)          o_cmd.op = DP_MOD_INIT;
                else                           o_cmd.op = DP_CLAMP;
            end
            S_MOD:    o_cmd.op = DP_MOD_STEP;
            S_MODFIX: o_cmd.op = DP_MOD_FIX;
            S_LOC:    o_cmd.op = DP_LOCATE;
            S_SRD:    o_cmd.op = DP_SRCH_RD;
            S_SCMP:   o_cmd.op = DP_SRCH_CMP;
            S_T0:     o_cmd.op = DP_T0_RD;
            S_T1:     o_cmd.op = DP_T1_RD;
            S_T2:     o_cmd.op = DP_DELTA;
            S_DCHK:   o_cmd.op = DP_ALPHA_SET;
            S_DIV:    o_cmd.op = DP_DIV_STEP;
            S_POLY:   o_cmd.op = DP_MUL_AA;
            S_TT:     o_cmd.op = DP_LATCH_TT;
            S_TTM:    o_cmd.op = DP_MUL_TA;
            S_TTT:    o_cmd.op = DP_LATCH_TTT;
            S_H:      o_cmd.op = DP_H_CALC;
            S_CRDA:   o_cmd.op = DP_CRD_A;
            S_CRDB:   o_cmd.op = DP_CRD_B;
            S_DIRECT: o_cmd.op = DP_DIRECT;
            S_P2:     o_cmd.op = DP_LATCH_P2;
            S_LMUL:   o_cmd.op = DP_LIN_MUL;
            S_LRES:   o_cmd.op = DP_LIN_RES;
            S_C1:     o_cmd.op = DP_C1;
            S_C2:     o_cmd.op = DP_C2;
            S_C3:     o_cmd.op = DP_C3;
            S_C4:     o_cmd.op = DP_C4;
            S_C5:     o_cmd.op = DP_C5;
            S_C6:     o_cmd.op = DP_C6;
            S_C7:     o_cmd.op = DP_C7;
            S_C8:     o_cmd.op = DP_C8;
            S_EMIT:   o_cmd.op = i_stat.out_free ? DP_EMIT : DP_NOP;
            default:  o_cmd.op = DP_NOP;
        endcase
    end

endmodule
`default_nettype wire

### hdl/kts_dp.sv
`default_nettype none
module kts_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_idx,
    input  wire logic [kts_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic [kts_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  wire logic                               i_in_user,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic [kts_pkg::OUT_TDATA_W-1:0]         o_out_data,
    output logic                                    o_out_user,
    output logic                                    o_out_last,
    input  wire kts_pkg::t_dp_cmd                   i_cmd,
    output kts_pkg::t_dp_stat                       o_stat
);
    import kts_pkg::*;

    // configuration
    logic [MODE_W-1:0] r_interp;
    logic [CNT_W-1:0]  r_key_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp    <= MODE_LINEAR;
            r_key_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INTERP_MODE: r_interp    <= i_cfg_data[MODE_W-1:0];
                REG_KEY_COUNT:   r_key_count <= i_cfg_data[CNT_W-1:0];
                default:         r_interp    <= r_interp;
            endcase
        end
    end

    // input fields
    logic [KEY_W-1:0]      w_slot;
    logic [COMP_W-1:0]     w_comp_in;
    logic [Q_W-1:0]        w_key_time;
    logic [Q_W-1:0]        w_key_value;
    logic [Q_W-1:0]        w_slope_in;
    logic [Q_W-1:0]        w_slope_out;
    logic signed [Q_W-1:0] w_sample_time;
    logic                  w_wrap;

    assign w_slot        = i_in_data[5:0];
    assign w_comp_in     = i_in_data[7:6];
    assign w_key_time    = i_in_data[39:8];
    assign w_key_value   = i_in_data[71:40];
    assign w_slope_in    = i_in_data[103:72];
    assign w_slope_out   = i_in_data[135:104];
    assign w_sample_time = $signed(i_in_data[167:136]);
    assign w_wrap        = i_in_data[168];

    // working registers
    logic signed [Q_W-1:0]     r_t, r_start, r_end, r_t0;
    logic signed [Q_W:0]       r_delta, r_dt;
    logic [Q_W:0]              r_span, r_mag, r_rem;
    logic                      r_neg, r_wrap, r_bad;
    logic [STEP_W-1:0]         r_cnt;
    logic [KEY_W-1:0]          r_i, r_idx;
    logic [ALPHA_W-1:0]        r_alpha, r_tt, r_ttt;
    logic signed [H_W-1:0]     r_h1, r_h2, r_h3, r_h4;
    logic signed [Q_W-1:0]     r_p1, r_p2, r_os, r_is, r_s1, r_s2, r_res;
    logic signed [PROD_W-1:0]  r_prod, r_acc;
    logic [COMP_W-1:0]         r_comp;

    logic [CNT_W-1:0]  w_size;
    logic [KEY_W-1:0]  w_last;
    logic              w_direct;
    logic              w_load;

    assign w_size   = (r_key_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : r_key_count;
    assign w_last   = KEY_W'(w_size - CNT_W'(1));
    assign w_direct = (r_interp == MODE_STEP) || (r_idx == w_last);
    assign w_load   = (i_cmd.op == DP_CAPTURE) && (i_in_user == FUNC_LOAD)
                      && (w_comp_in < COMP_W'(COMPONENTS));

    // key stores
    logic [Q_W-1:0] mem_time [0:MAX_KEYS-1];
    logic [Q_W-1:0] mem_val  [0:VAL_DEPTH-1];
    logic [Q_W-1:0] mem_in   [0:VAL_DEPTH-1];
    logic [Q_W-1:0] mem_out  [0:VAL_DEPTH-1];
    logic [Q_W-1:0] r_time_q, r_val_q, r_in_q, r_out_q;

    logic [VAL_AW-1:0] w_ld_addr, w_addr_a, w_addr_b, w_val_addr, w_in_addr;
    logic [KEY_W-1:0]  w_time_addr;
    logic              w_use_b;

    assign w_ld_addr = VAL_AW'(w_slot) * VAL_AW'(COMPONENTS) + VAL_AW'(w_comp_in);
    assign w_addr_a  = VAL_AW'(r_idx) * VAL_AW'(COMPONENTS) + VAL_AW'(r_comp);
    assign w_addr_b  = (VAL_AW'(r_idx) + VAL_AW'(1)) * VAL_AW'(COMPONENTS)
                       + VAL_AW'(r_comp);
    assign w_use_b    = !w_direct && (i_cmd.op == DP_CRD_A || i_cmd.op == DP_CRD_B);
    assign w_val_addr = (w_use_b && i_cmd.op == DP_CRD_B) ? w_addr_b : w_addr_a;
    assign w_in_addr  = w_use_b ? w_addr_b : w_addr_a;

    always_comb begin
        unique case (i_cmd.op)
            DP_RD_START: w_time_addr = '0;
            DP_RD_END:   w_time_addr = w_last;
            DP_T0_RD:    w_time_addr = r_idx;
            DP_T1_RD:    w_time_addr = r_idx + KEY_W'(1);
            default:     w_time_addr = r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            mem_time[w_slot]   <= w_key_time;
            mem_val[w_ld_addr] <= w_key_value;
            mem_in[w_ld_addr]  <= w_slope_in;
            mem_out[w_ld_addr] <= w_slope_out;
        end
        r_time_q <= mem_time[w_time_addr];
        r_val_q  <= mem_val[w_val_addr];
        r_in_q   <= mem_in[w_in_addr];
        r_out_q  <= mem_out[w_addr_a];
    end

    // shared multiplier, product registered every cycle
    logic signed [Q_W:0]      w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [Q_W:0]      w_alpha_s, w_tt_s;

    assign w_alpha_s = $signed({{(Q_W+1-ALPHA_W){1'b0}}, r_alpha});
    assign w_tt_s    = $signed({{(Q_W+1-ALPHA_W){1'b0}}, r_tt});

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.op)
            DP_MUL_AA:  begin w_mul_a = w_alpha_s; w_mul_b = w_alpha_s; end
            DP_MUL_TA:  begin w_mul_a = w_tt_s;    w_mul_b = w_alpha_s; end
            DP_LIN_MUL: begin
                w_mul_a = (Q_W+1)'(r_p2) - (Q_W+1)'(r_p1);
                w_mul_b = w_alpha_s;
            end
            DP_C1:   begin w_mul_a = (Q_W+1)'(r_os); w_mul_b = r_delta; end
            DP_C2:   begin w_mul_a = (Q_W+1)'(r_is); w_mul_b = r_delta; end
            DP_C3:   begin w_mul_a = (Q_W+1)'(r_p1); w_mul_b = (Q_W+1)'(r_h1); end
            DP_C4:   begin w_mul_a = (Q_W+1)'(r_p2); w_mul_b = (Q_W+1)'(r_h2); end
            DP_C5:   begin w_mul_a = (Q_W+1)'(r_s1); w_mul_b = (Q_W+1)'(r_h3); end
            DP_C6:   begin w_mul_a = (Q_W+1)'(r_s2); w_mul_b = (Q_W+1)'(r_h4); end
            default: begin w_mul_a = '0; w_mul_b = '0; end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // iterative remainder / quotient step
    logic [Q_W+1:0]          w_mrem2, w_drem2;
    logic signed [Q_W:0]     w_a;
    logic [Q_W:0]            w_r;
    logic signed [Q_W:0]     w_dt_now, w_delta_now;
    logic signed [H_W-1:0]   w_tt20, w_ttt20, w_al20;

    assign w_mrem2     = {r_rem, r_mag[Q_W]};
    assign w_drem2     = {r_rem, 1'b0};
    assign w_a         = (Q_W+1)'(r_t) - (Q_W+1)'(r_start);
    assign w_r         = (r_neg && r_rem != '0) ? (r_span - r_rem) : r_rem;
    assign w_dt_now    = (Q_W+1)'(r_t) - (Q_W+1)'(r_t0);
    assign w_delta_now = (Q_W+1)'($signed(r_time_q)) - (Q_W+1)'(r_t0);
    assign w_tt20      = $signed(H_W'(r_tt));
    assign w_ttt20     = $signed(H_W'(r_ttt));
    assign w_al20      = $signed(H_W'(r_alpha));

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_CAPTURE: begin
                r_t    <= w_sample_time;
                r_wrap <= w_wrap;
                r_comp <= '0;
                r_bad  <= 1'b0;
            end
            DP_BAD:       r_bad   <= 1'b1;
            DP_RD_END:    r_start <= $signed(r_time_q);
            DP_LATCH_END: r_end   <= $signed(r_time_q);
            DP_MOD_INIT: begin
                r_neg  <= w_a[Q_W];
                r_mag  <= w_a[Q_W] ? $unsigned(-w_a) : $unsigned(w_a);
                r_rem  <= '0;
                r_cnt  <= MOD_STEPS;
                r_span <= $unsigned((Q_W+1)'(r_end) - (Q_W+1)'(r_start));
            end
            DP_MOD_STEP: begin
                r_mag <= {r_mag[Q_W-1:0], 1'b0};
                r_cnt <= r_cnt - STEP_W'(1);
                if (w_mrem2 >= {1'b0, r_span}) begin
                    r_rem <= (Q_W+1)'(w_mrem2 - {1'b0, r_span});
                end else begin
                    r_rem <= w_mrem2[Q_W:0];
                end
            end
            DP_MOD_FIX: r_t <= Q_W'((Q_W+1)'(r_start) + $signed(w_r));
            DP_CLAMP: begin
                priority if (r_t <= r_start) r_t <= r_start;
                else if (r_t >= r_end)       r_t <= r_end;
                else                         r_t <= r_t;
            end
            DP_LOCATE: begin
                r_i   <= w_last - KEY_W'(1);
                r_idx <= (r_t >= r_end) ? w_last : '0;
            end
            DP_SRCH_CMP: begin
                if (r_t >= $signed(r_time_q)) begin
                    r_idx <= r_i;
                end else begin
                    r_i <= r_i - KEY_W'(1);
                end
            end
            DP_T1_RD: r_t0 <= $signed(r_time_q);
            DP_DELTA: begin
                r_delta <= w_delta_now;
                r_dt    <= w_dt_now;
            end
            DP_ALPHA_SET: begin
                r_rem <= $unsigned(r_dt);
                r_cnt <= DIV_STEPS;
                if (r_delta <= 0) r_bad <= 1'b1;
                priority if (r_dt <= 0)    r_alpha <= '0;
                else if (r_dt >= r_delta)  r_alpha <= ALPHA_W'(65536);
                else                       r_alpha <= '0;
            end
            DP_DIV_STEP: begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (w_drem2 >= {1'b0, $unsigned(r_delta)}) begin
                    r_rem   <= (Q_W+1)'(w_drem2 - {1'b0, $unsigned(r_delta)});
                    r_alpha <= {r_alpha[ALPHA_W-2:0], 1'b1};
                end else begin
                    r_rem   <= w_drem2[Q_W:0];
                    r_alpha <= {r_alpha[ALPHA_W-2:0], 1'b0};
                end
            end
            DP_LATCH_TT:  r_tt  <= ALPHA_W'(f_round16(r_prod));
            DP_LATCH_TTT: r_ttt <= ALPHA_W'(f_round16(r_prod));
            DP_H_CALC: begin
                r_h1 <= (w_ttt20 <<< 1) - (w_tt20 + (w_tt20 <<< 1)) + H_W'(65536);
                r_h2 <= (w_tt20 + (w_tt20 <<< 1)) - (w_ttt20 <<< 1);
                r_h3 <= w_ttt20 - (w_tt20 <<< 1) + w_al20;
                r_h4 <= w_ttt20 - w_tt20;
            end
            DP_CRD_B: begin
                r_p1 <= $signed(r_val_q);
                r_os <= $signed(r_out_q);
                r_is <= $signed(r_in_q);
            end
            DP_DIRECT:   r_res <= r_p1;
            DP_LATCH_P2: r_p2  <= $signed(r_val_q);
            DP_LIN_RES:  r_res <= f_sat32(PROD_W'(r_p1) + f_round16(r_prod));
            DP_C2:       r_s1  <= f_sat32(f_round16(r_prod));
            DP_C3:       r_s2  <= f_sat32(f_round16(r_prod));
            DP_C4:       r_acc <= r_prod;
            DP_C5:       r_acc <= r_acc + r_prod;
            DP_C6:       r_acc <= r_acc + r_prod;
            DP_C7:       r_acc <= r_acc + r_prod;
            DP_C8:       r_res <= f_sat32(f_round16(r_acc));
            DP_EMIT:     r_comp <= r_comp + COMP_W'(1);
            default:     r_comp <= r_comp;
        endcase
    end

    // output register
    logic                   r_ovalid;
    logic [COMP_W-1:0]      r_o_comp;
    logic [Q_W-1:0]         r_o_val;
    logic                   r_o_ok;
    logic                   r_o_last;
    logic                   w_out_free;
    logic                   w_comp_last;

    assign w_out_free  = !r_ovalid || i_out_ready;
    assign w_comp_last = (r_comp == COMP_W'(COMPONENTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == DP_EMIT) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_EMIT) begin
            r_o_comp <= r_comp;
            r_o_val  <= r_bad ? '0 : r_res;
            r_o_ok   <= !r_bad;
            r_o_last <= w_comp_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {6'b0, r_o_val, r_o_comp};
    assign o_out_user  = r_o_ok;
    assign o_out_last  = r_o_last;

    // status
    always_comb begin
        o_stat.func        = i_in_user;
        o_stat.size_lt2    = (w_size < CNT_W'(2));
        o_stat.range_bad   = (r_end <= r_start);
        o_stat.wrap        = r_wrap;
        o_stat.cnt_done    = (r_cnt == STEP_W'(1));
        o_stat.t_le_start  = (r_t <= r_start);
        o_stat.t_ge_end    = (r_t >= r_end);
        o_stat.last_one    = (w_last == KEY_W'(1));
        o_stat.hit         = (r_t >= $signed(r_time_q));
        o_stat.i_one       = (r_i == KEY_W'(1));
        o_stat.direct      = w_direct;
        o_stat.delta_le0   = (r_delta <= 0);
        o_stat.alpha_fixed = (r_dt <= 0) || (r_dt >= r_delta);
        o_stat.cubic       = r_interp[1];
        o_stat.linear      = (r_interp == MODE_LINEAR);
        o_stat.bad         = r_bad;
        o_stat.comp_last   = w_comp_last;
        o_stat.out_free    = w_out_free;
    end

endmodule
`default_nettype wire

### hdl/keyframe_track_sampler.sv
// Keyframe track sampler, Q16.16, step / linear / cubic Hermite. Loads are taken back to back.
// Sample: setup, a modulo if looping, a key search, the key spacing, a serial divide and the
//   cubic basis, then a step (or last key), linear or cubic result per component; a short
//   track goes straight to results. Sample length is set by the key search and serial divide.
// Reset (i_rst_n low, synchronous): idle, output empty, interp_mode 1, key_count 0.
`default_nettype none
module keyframe_track_sampler (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_idx,
    input  wire logic [kts_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // key_slot[5:0], component[7:6], key_time[39:8], key_value[71:40],
    // slope_in[103:72], slope_out[135:104], sample_time[167:136], wrap[168]
    input  wire logic [kts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func[0]
    input  wire logic                               s_axis_tuser,
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // out_component[1:0], sampled[33:2]
    output logic [kts_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // ok[0]
    output logic                                    m_axis_tuser,
    // last
    output logic                                    m_axis_tlast
);
    import kts_pkg::*;

    // Controller sequences one transaction at a time; the datapath owns the
    // key stores, the serial remainder/quotient unit and the shared multiplier.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    kts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The output register parts the result side from the sequencer: the next
    // component is worked on while the previous one waits for tready.
    kts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule
`default_nettype wire

### hdl/kts_chk.sv
`default_nettype none
module kts_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    a_last_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[1:0] == 2'd2))
        else $error("last flag on wrong component");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[33:2] == 32'd0))
        else $error("invalid result carries nonzero value");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind keyframe_track_sampler kts_chk u_kts_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### sim/tb_top.sv
`default_nettype none
module tb_top;
    import kts_pkg::*;

    localparam logic [MODE_W-1:0] MODE_CUBIC = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALT   = 2'd3;
    localparam int SETTLE = 300;
    localparam int FILL_KEYS = 24;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        logic               func;
        logic [5:0]         slot;
        logic [1:0]         comp;
        logic signed [31:0] ktime;
        logic signed [31:0] kval;
        logic signed [31:0] sin;
        logic signed [31:0] sout;
        logic signed [31:0] stime;
        logic               wrap;
    } t_track_item;

    typedef struct {
        t_row_kind          kind;
        t_track_item        it;
        logic               cfg_idx;
        logic [6:0]         cfg_val;
        bit                 typed;
        logic signed [31:0] typed_val;
        logic               typed_ok;
    } t_row;

    typedef struct {
        logic [1:0]         comp;
        logic signed [31:0] val;
        logic               ok;
        logic               last;
    } t_sample_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;

    always #5 i_clk = ~i_clk;

    keyframe_track_sampler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // shadow track state and registers
    logic [1:0]         sh_mode;
    logic [6:0]         sh_count;
    logic signed [31:0] sh_times [MAX_KEYS];
    logic signed [31:0] sh_vals  [VAL_DEPTH];
    logic signed [31:0] sh_sin   [VAL_DEPTH];
    logic signed [31:0] sh_sout  [VAL_DEPTH];

    t_sample_res pending_q[$];
    int errors = 0;
    int n_samples = 0;
    int n_loads = 0;
    int n_results = 0;
    bit tx_calm = 0;
    bit rx_calm = 0;
    int rx_hold = 0;
    int rx_seen = 0;

    function automatic longint q_round(longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic longint q_sat(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Interpolate one component from key idx at adjusted time t.
    function automatic longint interp_comp(int idx, int last_idx, longint t, int c,
                                           logic [1:0] mode, output bit ok);
        int ai;
        int bi;
        longint p1, p2, t0, dlt, num, alpha, tt, ttt, h1, h2, h3, h4, s1, s2;
        ai = idx * COMPONENTS + c;
        p1 = sh_vals[ai];
        ok = 1;
        if (mode == MODE_STEP || idx == last_idx) return p1;
        bi = (idx + 1) * COMPONENTS + c;
        t0 = sh_times[idx];
        dlt = longint'(sh_times[idx + 1]) - t0;
        if (dlt <= 0) begin
            ok = 0;
            return 0;
        end
        num = (t - t0) * 65536;
        alpha = (num <= 0) ? 0 : num / dlt;
        if (alpha > 65536) alpha = 65536;
        p2 = sh_vals[bi];
        if (mode == MODE_LINEAR) return q_sat(p1 + q_round((p2 - p1) * alpha));
        tt  = q_round(alpha * alpha);
        ttt = q_round(tt * alpha);
        h1 = 2 * ttt - 3 * tt + 65536;
        h2 = -2 * ttt + 3 * tt;
        h3 = ttt - 2 * tt + alpha;
        h4 = ttt - tt;
        s1 = q_sat(q_round(longint'(sh_sout[ai]) * dlt));
        s2 = q_sat(q_round(longint'(sh_sin[bi]) * dlt));
        return q_sat(q_round(p1 * h1 + p2 * h2 + s1 * h3 + s2 * h4));
    endfunction

    // Apply one accepted transaction to the shadow track; queue its results.
    function automatic void track_apply(t_track_item it);
        int size, last_idx, idx, k;
        logic [1:0] mode;
        longint t, t_start, t_end, r;
        bit valid, ok;
        t_sample_res res;
        if (it.func == FUNC_LOAD) begin
            if (it.comp < COMPONENTS) begin
                k = it.slot * COMPONENTS + it.comp;
                sh_times[it.slot] = it.ktime;
                sh_vals[k] = it.kval;
                sh_sin[k]  = it.sin;
                sh_sout[k] = it.sout;
            end
            return;
        end
        size = (sh_count > MAX_KEYS) ? MAX_KEYS : sh_count;
        mode = (sh_mode > MODE_CUBIC) ? MODE_CUBIC : sh_mode;
        t = it.stime;
        valid = 1;
        idx = 0;
        last_idx = 0;
        if (size < 2) begin
            valid = 0;
        end else begin
            last_idx = size - 1;
            t_start = sh_times[0];
            t_end = sh_times[last_idx];
            if (t_end <= t_start) begin
                valid = 0;
            end else begin
                if (it.wrap) begin
                    r = (t - t_start) % (t_end - t_start);
                    if (r < 0) r += t_end - t_start;
                    t = t_start + r;
                end else if (t <= t_start) begin
                    t = t_start;
                end else if (t >= t_end) begin
                    t = t_end;
                end
                if (t <= t_start) idx = 0;
                else if (t >= t_end) idx = last_idx;
                else begin
                    for (k = last_idx - 1; k > 0; k--) begin
                        if (t >= sh_times[k]) begin
                            idx = k;
                            break;
                        end
                    end
                end
            end
        end
        for (k = 0; k < COMPONENTS; k++) begin
            ok = 0;
            r = 0;
            if (valid) r = interp_comp(idx, last_idx, t, k, mode, ok);
            if (!ok) r = 0;
            res.comp = k[1:0];
            res.val = r[31:0];
            res.ok = ok;
            res.last = (k == COMPONENTS - 1);
            pending_q.push_back(res);
        end
    endfunction

    // Offer one transaction; returns at the falling edge after acceptance.
    task automatic send_item(t_track_item it, bit typed, logic signed [31:0] tv, logic tok);
        int gap;
        t_sample_res res;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= IN_TDATA_W'({it.wrap, it.stime, it.sout, it.sin, it.kval,
                                     it.ktime, it.comp, it.slot});
        s_axis_tuser <= it.func;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (it.func == FUNC_SAMPLE) n_samples++;
        else n_loads++;
        if (typed && it.func == FUNC_SAMPLE) begin
            for (int c = 0; c < COMPONENTS; c++) begin
                res.comp = c[1:0];
                res.val = tv;
                res.ok = tok;
                res.last = (c == COMPONENTS - 1);
                pending_q.push_back(res);
            end
        end else begin
            track_apply(it);
        end
        @(negedge i_clk);
    endtask

    // Drain, let the block go idle, then write one register.
    task automatic write_reg(logic idx, logic [6:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == REG_INTERP_MODE) sh_mode = val[1:0];
        else sh_count = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_track_item load_item(int slot, int comp, logic signed [31:0] tm,
                                              logic signed [31:0] v);
        t_track_item it;
        it.func = FUNC_LOAD;
        it.slot = slot[5:0];
        it.comp = comp[1:0];
        it.ktime = tm;
        it.kval = v;
        it.sin = $urandom;
        it.sout = $urandom;
        it.stime = $urandom;
        it.wrap = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic t_track_item sample_item(logic signed [31:0] st, logic w);
        t_track_item it;
        it = load_item($urandom_range(0, 63), $urandom_range(0, 3), $urandom, $urandom);
        it.func = FUNC_SAMPLE;
        it.stime = st;
        it.wrap = w;
        return it;
    endfunction

    // result side: draw a stall after every accepted result
    always @(negedge i_clk) begin
        if (n_results != rx_seen) begin
            rx_seen = n_results;
            rx_hold = rx_calm ? 0 : $urandom_range(0, 12);
            if (($urandom_range(0, 39)) == 0) rx_calm = ~rx_calm;
        end
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sample_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                $error("unexpected result transaction: tdata %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tdata[1:0] !== want.comp) begin
                    $error("out_component: expected %0d, got %0d", want.comp,
                           m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[33:2] !== want.val) begin
                    $error("sampled: expected %h, got %h", want.val, m_axis_tdata[33:2]);
                    errors++;
                end
                if (m_axis_tuser !== want.ok) begin
                    $error("ok: expected %b, got %b", want.ok, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_track_item it;
        logic [1:0] modes[8];
        logic [6:0] counts[8];
        logic signed [31:0] tm;
        logic smp_wrap;
        int n_slots;
        longint span, lo;

        sh_mode = MODE_LINEAR;
        sh_count = 0;
        foreach (sh_times[i]) sh_times[i] = 0;
        foreach (sh_vals[i]) begin
            sh_vals[i] = 0;
            sh_sin[i] = 0;
            sh_sout[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table: empty track, a three key track, extremes, bad range
        row = '{kind: ROW_ITEM, it: sample_item(32'sh0001_0000, 1'b0), cfg_idx: 0,
                cfg_val: 0, typed: 1, typed_val: 0, typed_ok: 0};
        rows.push_back(row);
        for (int k = 0; k < 3; k++)
            for (int c = 0; c < 3; c++) begin
                row.kind = ROW_ITEM;
                row.typed = 0;
                row.it = load_item(k, c, k * 32'sh0001_0000,
                                   (c == 2) ? 32'sh7FFF_FFFF : (k + c) * 32'sh0002_0000);
                rows.push_back(row);
            end
        row.it = load_item(1, 3, 32'sh1234_5678, 32'sh0);   // component 3: dropped
        rows.push_back(row);
        row.kind = ROW_CFG; row.cfg_idx = REG_KEY_COUNT; row.cfg_val = 7'd3;
        rows.push_back(row);
        row.kind = ROW_ITEM;
        row.it = sample_item(32'sh0000_8000, 1'b0); rows.push_back(row);
        row.it = sample_item(32'sh8000_0000, 1'b0); rows.push_back(row);
        row.it = sample_item(32'sh7FFF_FFFF, 1'b0); rows.push_back(row);
        row.it = sample_item(32'sh8000_0000, 1'b1); rows.push_back(row);
        row.it = sample_item(32'sh0001_4000, 1'b1); rows.push_back(row);
        row.kind = ROW_CFG; row.cfg_idx = REG_INTERP_MODE; row.cfg_val = MODE_CUBIC;
        rows.push_back(row);
        row.kind = ROW_ITEM;
        row.it = sample_item(32'sh0001_8000, 1'b0); rows.push_back(row);
        // last key before the first one: reversed range
        row.it = load_item(2, 0, 32'sh8000_0000, 32'sh0); rows.push_back(row);
        row.it = sample_item(32'sh0000_8000, 1'b0);
        row.typed = 1; row.typed_val = 0; row.typed_ok = 0;
        rows.push_back(row);
        row.kind = ROW_CFG; row.cfg_idx = REG_KEY_COUNT; row.cfg_val = 7'd1;
        rows.push_back(row);
        row.kind = ROW_ITEM;
        row.it = sample_item(32'sh0000_8000, 1'b1); rows.push_back(row);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].cfg_idx, rows[i].cfg_val);
            else
                send_item(rows[i].it, rows[i].typed, rows[i].typed_val, rows[i].typed_ok);
        end

        // fill the low keys and the top key; longer tracks are only sampled at
        // their ends, so no sample touches an unwritten entry
        tm = $urandom_range(0, 1) ? -$signed(32'($urandom_range(0, 1 << 22))) : 32'sd0;
        for (int k = 0; k < FILL_KEYS; k++) begin
            if (k > 0) tm = tm + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32'h3_0000));
            for (int c = 0; c < COMPONENTS; c++)
                send_item(load_item(k, c, tm, $urandom), 0, 0, 0);
        end
        tm = tm + 32'sh0001_0000;
        for (int c = 0; c < COMPONENTS; c++)
            send_item(load_item(MAX_KEYS - 1, c, tm, $urandom), 0, 0, 0);

        modes  = '{MODE_STEP, MODE_LINEAR, MODE_CUBIC, MODE_ALT,
                   MODE_CUBIC, MODE_LINEAR, MODE_CUBIC, MODE_STEP};
        counts = '{7'd24, 7'd2, 7'd127, 7'd5, 7'd0, 7'd17, 7'd64, 7'd9};
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_INTERP_MODE, modes[ph]);
            write_reg(REG_KEY_COUNT, counts[ph]);
            tx_calm = ($urandom_range(0, 3) == 0);
            n_slots = (counts[ph] > MAX_KEYS) ? MAX_KEYS : counts[ph];
            for (int n = 0; n < 11; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    // rewrite a key; usually keep its time so the track stays ordered
                    it = load_item($urandom_range(0, 63), $urandom_range(0, 3),
                                   $urandom, $urandom);
                    if ($urandom_range(0, 9) < 8) it.ktime = sh_times[it.slot];
                    send_item(it, 0, 0, 0);
                end else begin
                    tm = $urandom;
                    smp_wrap = $urandom_range(0, 1);
                    if (n_slots > FILL_KEYS) begin
                        // clamp at or beyond either end of the long track
                        smp_wrap = 1'b0;
                        if ($urandom_range(0, 1))
                            tm = 32'(q_sat(longint'(sh_times[0])
                                           - longint'($urandom_range(0, 32'h1_0000))));
                        else
                            tm = 32'(q_sat(longint'(sh_times[MAX_KEYS - 1])
                                           + longint'($urandom_range(0, 32'h1_0000))));
                    end else if (n_slots >= 2 && $urandom_range(0, 3) != 0) begin
                        lo = sh_times[0];
                        span = longint'(sh_times[n_slots - 1]) - lo;
                        if (span < 4) span = 4;
                        tm = 32'(q_sat(lo - span / 4
                                       + longint'($urandom_range(0, 32'hFFFF_FFFF))
                                       % (span + span / 2)));
                    end
                    send_item(sample_item(tm, smp_wrap), 0, 0, 0);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        $display("covered %0d sample and %0d load transactions, %0d results checked",
                 n_samples, n_loads, n_results);
        $display("modes step, linear, cubic and 3; key counts 0 to 127 incl. saturation");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
hdl/kts_pkg.sv
hdl/kts_ctrl.sv
hdl/kts_dp.sv
hdl/keyframe_track_sampler.sv
hdl/kts_chk.sv
sim/tb_top.sv
